// ===== src/mhl_pkg.sv =====
// Shared types, constants and helpers for the motion-hold HSV LED frame engine.
package mhl_pkg;

  localparam int LED_COUNT_DEF   = 64;
  localparam int IDX_W           = 6;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int PWM_W           = 12;

  localparam logic [7:0] MOD_BASE    = 8'd255;
  localparam logic [7:0] FULL_SCALE  = 8'd255;
  localparam logic [7:0] BRIGHT_BYTE = 8'hE1;
  localparam logic [7:0] SECTOR_SPAN = 8'd43;
  localparam logic [7:0] SAT_RESET   = 8'd254;

  localparam logic [15:0]      HOLD_TIME_RST  = 16'd5000;
  localparam logic [7:0]       TICK_STEP_RST  = 8'd10;
  localparam logic [PWM_W-1:0] PWM_FULL_RST   = 12'd2047;
  localparam logic [PWM_W-1:0] RAMP_STEP_RST  = 12'd30;
  localparam logic [7:0]       HUE_STRIDE_RST = 8'd30;
  localparam logic [7:0]       SAT_STEP_RST   = 8'd16;
  localparam logic [7:0]       LIT_VALUE_RST  = 8'd255;
  localparam logic [7:0]       DIM_VALUE_RST  = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HOLD_TIME,
    REG_TICK_STEP,
    REG_PWM_FULL,
    REG_RAMP_STEP,
    REG_HUE_STRIDE,
    REG_SAT_STEP,
    REG_LIT_VALUE,
    REG_DIM_VALUE
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      hold_time;
    logic [7:0]       tick_step;
    logic [PWM_W-1:0] pwm_full;
    logic [PWM_W-1:0] ramp_step;
    logic [7:0]       hue_stride;
    logic [7:0]       sat_step;
    logic [7:0]       lit_value;
    logic [7:0]       dim_value;
  } cfg_t;

  typedef struct packed {
    logic             lamp;
    logic [PWM_W-1:0] pwm;
    logic [7:0]       sat;
    logic [7:0]       base_hue;
    logic [7:0]       value;
  } tick_state_t;

  typedef struct packed {
    logic       start;
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] value;
  } hsv_req_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } hsv_rsp_t;

  // a and b both below 256; a stays below 255, so one subtract folds the sum
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, MOD_BASE}) begin
      sum = sum - {1'b0, MOD_BASE};
    end
    return sum[7:0];
  endfunction

endpackage

// ===== src/mhl_if.sv =====
// Stream interfaces for tick input beats and pixel result beats.
interface mhl_tick_if;
  logic valid;
  logic ready;
  logic motion_seen;
  logic touch_level;

  modport source(output valid, output motion_seen, output touch_level, input ready);
  modport sink(input valid, input motion_seen, input touch_level, output ready);
endinterface

interface mhl_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [mhl_pkg::IDX_W-1:0]    led_index;
  logic [31:0]                  frame_word;
  logic [mhl_pkg::PWM_W-1:0]    motor_level;
  logic                         lamp_on;
  logic                         last_pixel;

  modport source(output valid, output led_index, output frame_word, output motor_level,
                 output lamp_on, output last_pixel, input ready);
  modport sink(input valid, input led_index, input frame_word, input motor_level,
               input lamp_on, input last_pixel, output ready);
endinterface

// ===== src/mhl_tick.sv =====
// Per-tick lamp, hold counter, saturation, motor ramp and base hue state.
module mhl_tick (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 apply,
  input  logic                 motion_seen,
  input  logic                 touch_level,
  input  mhl_pkg::cfg_t        cfg,
  output mhl_pkg::tick_state_t st
);

  localparam int PWM_W = mhl_pkg::PWM_W;

  logic [15:0]      hold_count, hold_next, hold_a;
  logic             lamp, lamp_next, lamp_a;
  logic [PWM_W-1:0] pwm, pwm_next;
  logic [PWM_W:0]   pwm_sum;
  logic             touch_prev;
  logic [7:0]       sat, sat_next;
  logic [7:0]       base_hue, hue_next;

  always_comb begin
    hold_a = motion_seen ? cfg.hold_time : hold_count;
    lamp_a = motion_seen | lamp;

    sat_next = (touch_level && !touch_prev) ? mhl_pkg::add_mod255(sat, cfg.sat_step) : sat;

    // expire the lamp on an empty counter, else drop it, saturating at zero
    if (hold_a == 16'd0) begin
      lamp_next = 1'b0;
      hold_next = hold_a;
    end else begin
      lamp_next = lamp_a;
      hold_next = (hold_a > {8'd0, cfg.tick_step}) ? hold_a - {8'd0, cfg.tick_step} : 16'd0;
    end

    pwm_sum = {1'b0, pwm} + {1'b0, cfg.ramp_step};
    if (lamp_next) begin
      if (pwm < cfg.pwm_full) begin
        pwm_next = (pwm_sum > {1'b0, cfg.pwm_full}) ? cfg.pwm_full : pwm_sum[PWM_W-1:0];
      end else begin
        pwm_next = pwm;
      end
    end else begin
      pwm_next = (pwm > cfg.ramp_step) ? pwm - cfg.ramp_step : '0;
    end

    hue_next = mhl_pkg::add_mod255(base_hue, 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_count <= '0;
      lamp       <= 1'b0;
      pwm        <= '0;
      touch_prev <= 1'b0;
      sat        <= mhl_pkg::SAT_RESET;
      base_hue   <= '0;
    end else if (apply) begin
      hold_count <= hold_next;
      lamp       <= lamp_next;
      pwm        <= pwm_next;
      touch_prev <= touch_level;
      sat        <= sat_next;
      base_hue   <= hue_next;
    end
  end

  always_comb begin
    st.lamp     = lamp;
    st.pwm      = pwm;
    st.sat      = sat;
    st.base_hue = base_hue;
    st.value    = lamp ? cfg.lit_value : cfg.dim_value;
  end

endmodule

// ===== src/mhl_hsv.sv =====
// Iterative HSV-to-RGB converter around one shared 8x8 multiplier.
module mhl_hsv (
  input  logic              clk,
  input  logic              rst,
  input  mhl_pkg::hsv_req_t req,
  output mhl_pkg::hsv_rsp_t rsp
);

  typedef enum logic [2:0] {
    SEC_RED,
    SEC_YELLOW,
    SEC_GREEN,
    SEC_CYAN,
    SEC_BLUE,
    SEC_MAGENTA
  } sector_t;

  typedef enum logic [2:0] {
    STEP_X,
    STEP_Y,
    STEP_P,
    STEP_Q,
    STEP_T
  } step_t;

  localparam logic [7:0] SPAN = mhl_pkg::SECTOR_SPAN;
  localparam logic [7:0] FULL = mhl_pkg::FULL_SCALE;
  localparam logic [7:0] B1   = 8'(SPAN * 1);
  localparam logic [7:0] B2   = 8'(SPAN * 2);
  localparam logic [7:0] B3   = 8'(SPAN * 3);
  localparam logic [7:0] B4   = 8'(SPAN * 4);
  localparam logic [7:0] B5   = 8'(SPAN * 5);

  sector_t    sec_c, sector;
  logic [7:0] base_c, offset_c, frac_c;
  logic [7:0] frac, s, v, x, y, p, q, t;
  logic [7:0] op_a, op_b;
  logic [15:0] prod;
  step_t      step;
  logic       busy, valid;

  // sector and fraction of the incoming hue
  always_comb begin
    if (req.hue < B1) begin
      sec_c = SEC_RED;     base_c = 8'd0;
    end else if (req.hue < B2) begin
      sec_c = SEC_YELLOW;  base_c = B1;
    end else if (req.hue < B3) begin
      sec_c = SEC_GREEN;   base_c = B2;
    end else if (req.hue < B4) begin
      sec_c = SEC_CYAN;    base_c = B3;
    end else if (req.hue < B5) begin
      sec_c = SEC_BLUE;    base_c = B4;
    end else begin
      sec_c = SEC_MAGENTA; base_c = B5;
    end
    offset_c = req.hue - base_c;
    frac_c   = (offset_c << 2) + (offset_c << 1);
  end

  always_comb begin
    unique case (step)
      STEP_X:  begin op_a = s; op_b = frac;        end
      STEP_Y:  begin op_a = s; op_b = FULL - frac; end
      STEP_P:  begin op_a = v; op_b = FULL - s;    end
      STEP_Q:  begin op_a = v; op_b = FULL - x;    end
      STEP_T:  begin op_a = v; op_b = FULL - y;    end
      default: begin op_a = s; op_b = frac;        end
    endcase
    prod = op_a * op_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      step  <= STEP_X;
    end else if (req.start) begin
      busy   <= 1'b1;
      valid  <= 1'b0;
      step   <= STEP_X;
      sector <= sec_c;
      frac   <= frac_c;
      s      <= req.sat;
      v      <= req.value;
    end else if (busy) begin
      unique case (step)
        STEP_X:  begin x <= prod[15:8]; step <= STEP_Y; end
        STEP_Y:  begin y <= prod[15:8]; step <= STEP_P; end
        STEP_P:  begin p <= prod[15:8]; step <= STEP_Q; end
        STEP_Q:  begin q <= prod[15:8]; step <= STEP_T; end
        STEP_T:  begin
          t     <= prod[15:8];
          busy  <= 1'b0;
          valid <= 1'b1;
          step  <= STEP_X;
        end
        default: step <= STEP_X;
      endcase
    end
  end

  always_comb begin
    rsp.valid = valid;
    if (s == 8'd0) begin
      rsp.red = v; rsp.green = v; rsp.blue = v;
    end else begin
      unique case (sector)
        SEC_RED:     begin rsp.red = v; rsp.green = t; rsp.blue = p; end
        SEC_YELLOW:  begin rsp.red = q; rsp.green = v; rsp.blue = p; end
        SEC_GREEN:   begin rsp.red = p; rsp.green = v; rsp.blue = t; end
        SEC_CYAN:    begin rsp.red = p; rsp.green = q; rsp.blue = v; end
        SEC_BLUE:    begin rsp.red = t; rsp.green = p; rsp.blue = v; end
        default:     begin rsp.red = v; rsp.green = p; rsp.blue = q; end
      endcase
    end
  end

endmodule

// ===== src/motion_hold_hsv_led_frame_engine_top.sv =====
// Top level of the motion-hold lamp and HSV LED frame engine.
//
// Usage: one beat on the tick channel (motion_seen, touch_level) is one system
// tick. It updates the hold counter, lamp, saturation, motor ramp and base hue,
// then the block emits LED_COUNT beats on the pixel channel, one per LED:
// led_index, frame_word {red, green, blue, 0xE1}, motor_level, lamp_on, and
// last_pixel on the final one. Registers are written on cfg_we with cfg_index
// and cfg_data; the user must do so only while the block is idle (not enforced).
// Each pixel takes a load state, five passes through the shared 8x8 multiplier
// in the HSV unit and a hand-off into the output register; S_FIRST comes before
// the first pixel. tick.ready stays low from the tick beat until the last pixel
// word sits in the output register.
// Stall: a result waits in the output register while the next pixel is
// computed; the sequencer holds once a second result is ready.
// Reset: rst (synchronous) restores register defaults, clears the lamp, hold
// counter, motor level and hue, sets saturation to 254 and drops any pending
// pixel word.
module motion_hold_hsv_led_frame_engine_top #(
  parameter int LED_COUNT = mhl_pkg::LED_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  mhl_tick_if.sink                         tick,
  mhl_pixel_if.source                      pixel,
  input  logic                             cfg_we,
  input  logic [mhl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mhl_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = mhl_pkg::IDX_W;
  localparam int PWM_W = mhl_pkg::PWM_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIRST,
    S_START,
    S_CALC
  } state_t;

  state_t               state;
  mhl_pkg::cfg_t        cfg;
  mhl_pkg::tick_state_t ts;
  mhl_pkg::hsv_req_t    hreq;
  mhl_pkg::hsv_rsp_t    hrsp;

  logic [IDX_W-1:0] idx;
  logic [7:0]       hue_cur;
  logic             tick_beat;
  logic             out_load;

  // out registers
  logic             ov;
  logic [IDX_W-1:0] o_index;
  logic [31:0]      o_word;
  logic [PWM_W-1:0] o_motor;
  logic             o_lamp;
  logic             o_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hold_time  <= mhl_pkg::HOLD_TIME_RST;
      cfg.tick_step  <= mhl_pkg::TICK_STEP_RST;
      cfg.pwm_full   <= mhl_pkg::PWM_FULL_RST;
      cfg.ramp_step  <= mhl_pkg::RAMP_STEP_RST;
      cfg.hue_stride <= mhl_pkg::HUE_STRIDE_RST;
      cfg.sat_step   <= mhl_pkg::SAT_STEP_RST;
      cfg.lit_value  <= mhl_pkg::LIT_VALUE_RST;
      cfg.dim_value  <= mhl_pkg::DIM_VALUE_RST;
    end else if (cfg_we) begin
      unique case (mhl_pkg::cfg_reg_t'(cfg_index))
        mhl_pkg::REG_HOLD_TIME:  cfg.hold_time  <= cfg_data;
        mhl_pkg::REG_TICK_STEP:  cfg.tick_step  <= cfg_data[7:0];
        mhl_pkg::REG_PWM_FULL:   cfg.pwm_full   <= cfg_data[PWM_W-1:0];
        mhl_pkg::REG_RAMP_STEP:  cfg.ramp_step  <= cfg_data[PWM_W-1:0];
        mhl_pkg::REG_HUE_STRIDE: cfg.hue_stride <= cfg_data[7:0];
        mhl_pkg::REG_SAT_STEP:   cfg.sat_step   <= cfg_data[7:0];
        mhl_pkg::REG_LIT_VALUE:  cfg.lit_value  <= cfg_data[7:0];
        mhl_pkg::REG_DIM_VALUE:  cfg.dim_value  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign tick.ready = (state == S_IDLE);
  assign tick_beat  = tick.valid && tick.ready;

  mhl_tick u_tick (
    .clk         (clk),
    .rst         (rst),
    .apply       (tick_beat),
    .motion_seen (tick.motion_seen),
    .touch_level (tick.touch_level),
    .cfg         (cfg),
    .st          (ts)
  );

  // launch one HSV conversion per pixel
  always_comb begin
    hreq.start = (state == S_START);
    hreq.hue   = hue_cur;
    hreq.sat   = ts.sat;
    hreq.value = ts.value;
  end

  mhl_hsv u_hsv (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  // hand a finished pixel over once the output slot is free or draining
  assign out_load = (state == S_CALC) && hrsp.valid && (!ov || pixel.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (tick_beat) begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          // pick up the freshly advanced base hue
          hue_cur <= ts.base_hue;
          idx     <= '0;
          state   <= S_START;
        end
        S_START: begin
          state <= S_CALC;
        end
        S_CALC: begin
          if (out_load) begin
            o_index <= idx;
            o_word  <= {hrsp.red, hrsp.green, hrsp.blue, mhl_pkg::BRIGHT_BYTE};
            o_motor <= ts.pwm;
            o_lamp  <= ts.lamp;
            o_last  <= (idx == LAST_IDX);
            hue_cur <= mhl_pkg::add_mod255(hue_cur, cfg.hue_stride);
            idx     <= idx + 1'b1;
            state   <= (idx == LAST_IDX) ? S_IDLE : S_START;
          end
        end
        default: state <= S_IDLE;
      endcase
      // fill the output slot on a load, else drain it when the receiver takes it
      if (out_load) begin
        ov <= 1'b1;
      end else if (pixel.ready) begin
        ov <= 1'b0;
      end
    end
  end

  assign pixel.valid       = ov;
  assign pixel.led_index   = o_index;
  assign pixel.frame_word  = o_word;
  assign pixel.motor_level = o_motor;
  assign pixel.lamp_on     = o_lamp;
  assign pixel.last_pixel  = o_last;

  // a tick beat starts a frame: no second tick is taken right after it
  a_tick_blocks: assert property (@(posedge clk) disable iff (rst)
    tick_beat |=> !tick.ready)
    else $error("tick accepted while a frame was starting");

  // pixels still owed to the frame keep the tick channel closed
  a_frame_open: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready && !pixel.last_pixel |-> !tick.ready)
    else $error("tick channel open before the frame's last pixel");

  // the tick channel reopens only with the last pixel word in the output slot
  a_reopen_last: assert property (@(posedge clk) disable iff (rst)
    $rose(tick.ready) |-> pixel.valid && pixel.last_pixel)
    else $error("tick channel reopened without the last pixel pending");

endmodule

// ===== verif/mhl_frame_checker.sv =====
// Checker for the frame engine: predicts the pixel words of each tick beat and compares them.
module mhl_frame_checker import mhl_pkg::*; #(
  parameter int LED_COUNT = LED_COUNT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  mhl_tick_if                   tick,
  mhl_pixel_if                  pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    words_pending,
  output int                    words_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WRAP       = 255;
  localparam int unsigned FRAC_SCALE = 6;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [31:0]      word;
    logic [PWM_W-1:0] motor;
    logic             lamp;
    logic             last;
  } pixel_beat_t;

  cfg_t        regs;
  int unsigned hold_count;
  logic        lamp;
  int unsigned motor;
  logic        touch_prev;
  int unsigned sat;
  int unsigned base_hue;
  pixel_beat_t frame_q[$];
  int          fail_total = 0;
  int          checked_total = 0;

  function automatic logic [31:0] hsv_frame(int unsigned h, int unsigned s, int unsigned v);
    int unsigned sector, frac, p, q, t, r, g, b;
    if (s == 0) begin
      r = v;
      g = v;
      b = v;
    end else begin
      sector = h / SECTOR_SPAN;
      frac   = ((h - sector * SECTOR_SPAN) * FRAC_SCALE) & 8'hFF;
      p      = (v * (FULL_SCALE - s)) >> 8;
      q      = (v * (FULL_SCALE - ((s * frac) >> 8))) >> 8;
      t      = (v * (FULL_SCALE - ((s * (FULL_SCALE - frac)) >> 8))) >> 8;
      case (sector)
        0: begin r = v; g = t; b = p; end
        1: begin r = q; g = v; b = p; end
        2: begin r = p; g = v; b = t; end
        3: begin r = p; g = q; b = v; end
        4: begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
    end
    return {8'(r), 8'(g), 8'(b), BRIGHT_BYTE};
  endfunction

  function automatic void predict_tick(logic motion, logic touch);
    int          i;
    int unsigned value;
    int unsigned hue;
    pixel_beat_t beat;
    if (motion) begin
      hold_count = 32'(regs.hold_time);
      lamp       = 1'b1;
    end
    if (touch && !touch_prev) begin
      sat = (sat + regs.sat_step) % WRAP;
    end
    touch_prev = touch;
    if (hold_count == 0) begin
      lamp = 1'b0;
    end else begin
      hold_count = (hold_count > regs.tick_step) ? hold_count - regs.tick_step : 0;
    end
    if (lamp) begin
      if (motor < regs.pwm_full) begin
        motor = motor + regs.ramp_step;
        if (motor > regs.pwm_full) begin
          motor = 32'(regs.pwm_full);
        end
      end
    end else if (motor > 0) begin
      motor = (motor > regs.ramp_step) ? motor - regs.ramp_step : 0;
    end
    base_hue = (base_hue + 1) % WRAP;
    value    = lamp ? 32'(regs.lit_value) : 32'(regs.dim_value);
    for (i = 0; i < LED_COUNT; i++) begin
      hue        = (base_hue + i * regs.hue_stride) % WRAP;
      beat.index = IDX_W'(i);
      beat.word  = hsv_frame(hue, sat, value);
      beat.motor = PWM_W'(motor);
      beat.lamp  = lamp;
      beat.last  = (i == LED_COUNT - 1);
      frame_q.push_back(beat);
    end
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s expected 0x%0h got 0x%0h", name, want, got);
      fail_total++;
    end
  endfunction

  function automatic void check_word();
    pixel_beat_t want;
    if (frame_q.size() == 0) begin
      $error("pixel word for index %0d arrived with no tick outstanding", pixel.led_index);
      fail_total++;
      return;
    end
    want = frame_q.pop_front();
    check_field("led_index", 32'(want.index), 32'(pixel.led_index));
    check_field("frame_word", want.word, pixel.frame_word);
    check_field("motor_level", 32'(want.motor), 32'(pixel.motor_level));
    check_field("lamp_on", 32'(want.lamp), 32'(pixel.lamp_on));
    check_field("last_pixel", 32'(want.last), 32'(pixel.last_pixel));
    checked_total++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      regs.hold_time  = HOLD_TIME_RST;
      regs.tick_step  = TICK_STEP_RST;
      regs.pwm_full   = PWM_FULL_RST;
      regs.ramp_step  = RAMP_STEP_RST;
      regs.hue_stride = HUE_STRIDE_RST;
      regs.sat_step   = SAT_STEP_RST;
      regs.lit_value  = LIT_VALUE_RST;
      regs.dim_value  = DIM_VALUE_RST;
      hold_count      = 0;
      lamp            = 1'b0;
      motor           = 0;
      touch_prev      = 1'b0;
      sat             = 32'(SAT_RESET);
      base_hue        = 0;
      frame_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOLD_TIME:  regs.hold_time  = cfg_data;
          REG_TICK_STEP:  regs.tick_step  = cfg_data[7:0];
          REG_PWM_FULL:   regs.pwm_full   = cfg_data[PWM_W-1:0];
          REG_RAMP_STEP:  regs.ramp_step  = cfg_data[PWM_W-1:0];
          REG_HUE_STRIDE: regs.hue_stride = cfg_data[7:0];
          REG_SAT_STEP:   regs.sat_step   = cfg_data[7:0];
          REG_LIT_VALUE:  regs.lit_value  = cfg_data[7:0];
          REG_DIM_VALUE:  regs.dim_value  = cfg_data[7:0];
          default: ;
        endcase
      end
      // a word taken at the same edge as a tick beat belongs to an earlier tick
      if (pixel.valid && pixel.ready) begin
        check_word();
      end
      if (tick.valid && tick.ready) begin
        predict_tick(tick.motion_seen, tick.touch_level);
      end
    end
    mismatches    <= fail_total;
    words_pending <= frame_q.size();
    words_checked <= checked_total;
  end

endmodule

// ===== verif/tb_top.sv =====
// Top of the frame engine testbench: clock, reset, register settings, tick stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mhl_pkg::*;

  localparam int LIMIT         = 1_500_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD     = 500;
  localparam int FIRST_HOLD_AT = 3000;
  localparam int HOLD_SPACING  = 12000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_TICKS   = 59;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  bit                    idle_on;
  int                    ticks_sent;
  int                    settings_used;
  int                    cycle_count = 0;
  int                    mismatches;
  int                    words_pending;
  int                    words_checked;

  mhl_tick_if  tick_ch();
  mhl_pixel_if pixel_ch();

  motion_hold_hsv_led_frame_engine_top #(
    .LED_COUNT(LED_COUNT_DEF)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .tick     (tick_ch),
    .pixel    (pixel_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // The checker sees every beat on both channels and every register write.
  mhl_frame_checker #(
    .LED_COUNT(LED_COUNT_DEF)
  ) u_checker (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick_ch),
    .pixel        (pixel_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .words_pending(words_pending),
    .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a lost pixel word ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Pixel receiver: random short stalls while idling is allowed, plus a long
  // hold-off at fixed beat counts so the engine backs up into the tick channel.
  initial begin
    int stall_left;
    int beats;
    int next_hold_at;
    stall_left   = 0;
    beats        = 0;
    next_hold_at = FIRST_HOLD_AT;
    pixel_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pixel_ch.valid && pixel_ch.ready) begin
        beats++;
        if (beats == next_hold_at) begin
          stall_left   = LONG_HOLD;
          next_hold_at = next_hold_at + HOLD_SPACING;
        end
      end
      if (stall_left > 0) begin
        pixel_ch.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pixel_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        pixel_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one tick beat, maybe after a short gap, and hold it until taken.
  task automatic send_tick(logic motion, logic touch);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      tick_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.motion_seen <= motion;
    tick_ch.touch_level <= touch;
    do @(posedge clk); while (!tick_ch.ready);
    ticks_sent++;
  endtask

  // Drop valid and wait for every predicted word to come back.
  task automatic settle();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t which, logic [15:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
  endtask

  // Write all eight registers back to back; only called while the engine is idle.
  task automatic apply_settings(logic [15:0] hold, logic [15:0] step, logic [15:0] full,
                                logic [15:0] ramp, logic [15:0] stride,
                                logic [15:0] sat_inc, logic [15:0] lit, logic [15:0] dim);
    write_reg(REG_HOLD_TIME, hold);
    write_reg(REG_TICK_STEP, step);
    write_reg(REG_PWM_FULL, full);
    write_reg(REG_RAMP_STEP, ramp);
    write_reg(REG_HUE_STRIDE, stride);
    write_reg(REG_SAT_STEP, sat_inc);
    write_reg(REG_LIT_VALUE, lit);
    write_reg(REG_DIM_VALUE, dim);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random settings: hold times and steps lean small so the lamp toggles often.
  task automatic random_settings();
    apply_settings(
      16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 40)),
      16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 255) : $urandom_range(1, 8)),
      16'($urandom_range(0, 4095)),
      16'(($urandom_range(0, 1) == 0) ? $urandom_range(1, 4095) : $urandom_range(1, 200)),
      16'($urandom_range(0, 254)), 16'($urandom_range(0, 254)),
      16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)));
  endtask

  task automatic random_ticks(int count);
    int motion_pct;
    motion_pct = $urandom_range(3, 60);
    repeat (count) begin
      send_tick($urandom_range(1, 100) <= motion_pct, 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = REG_HOLD_TIME;
    cfg_data            = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.motion_seen = 1'b0;
    tick_ch.touch_level = 1'b0;
    idle_on             = 1'b1;
    ticks_sent          = 0;
    settings_used       = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: dim then lit frames; touch edges wrap saturation from 254 to 15, then 31.
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    settle();

    // Short hold with step 1: watch the count run out and the lamp expire.
    // The saturation step lands the next touch edge on zero, giving grey words.
    apply_settings(3, 1, 100, 40, 254, 224, 255, 0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    // Zero tick step with the longest hold: lamp stays lit, motor clamps at full scale.
    apply_settings(65535, 0, 4095, 4095, 0, 254, 0, 255);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    // Ceiling zero and ramp zero: motor sits above the ceiling, then zero hold
    // turns the lamp off in the motion tick itself.
    apply_settings(0, 255, 0, 0, 127, 0, 128, 255);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 2) begin
        apply_settings(65535, 255, 4095, 4095, 254, 254, 255, 255);
      end else begin
        random_settings();
      end
      // keep the final stretch free of idling on both sides
      if (phase == RANDOM_PHASES - 1) begin
        idle_on = 1'b0;
      end
      random_ticks(PHASE_TICKS);
      settle();
    end

    $display("Summary: %0d tick beats under %0d register settings, %0d pixel words compared",
             ticks_sent, settings_used, words_checked);
    $display("Covered hold expiry, zero hold and step, motor clamps, grey, wraps, long stalls");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
